@@ rtl/core/u2u_pkg.sv @@
package u2u_pkg;

	localparam int BYTE_W          = 8;
	localparam int UNIT_W          = 16;
	localparam int PART_W          = 10;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	// one classified beat handed from the front to the back
	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              is_end;
		logic              bad;
	} u2u_op_t;

endpackage

@@ rtl/core/u2u_front.sv @@
module u2u_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [u2u_pkg::BYTE_W-1:0] data_byte,
	output logic                    push,
	output u2u_pkg::u2u_op_t        op
);
	import u2u_pkg::*;

	typedef enum logic [3:0] {
		PH_LEAD    = 4'b0001,
		PH_LAST    = 4'b0010,
		PH_TWO     = 4'b0100,
		PH_DISCARD = 4'b1000
	} u2u_phase_t;

	u2u_phase_t        phase_q, phase_d;
	logic [PART_W-1:0] part_q, part_d;
	logic              err_q, err_d;

	always_comb begin
		phase_d   = phase_q;
		part_d    = part_q;
		err_d     = err_q;
		push      = 1'b0;
		op.unit   = '0;
		op.is_end = 1'b0;
		op.bad    = 1'b0;
		if (accept) begin
			if (data_byte == '0) begin
				// terminator: a sequence still open counts as malformed
				push      = 1'b1;
				op.is_end = 1'b1;
				op.bad    = err_q | (phase_q != PH_LEAD);
				phase_d   = PH_LEAD;
				part_d    = '0;
				err_d     = 1'b0;
			end else begin
				case (phase_q)
					PH_LEAD: begin
						if (data_byte inside {[8'h01:8'h7F]}) begin
							push    = 1'b1;
							op.unit = UNIT_W'(data_byte);
						end else if (data_byte inside {[8'hC0:8'hDF]}) begin
							part_d  = PART_W'(data_byte[4:0]);
							phase_d = PH_LAST;
						end else if (data_byte inside {[8'hE0:8'hEF]}) begin
							part_d  = PART_W'(data_byte[3:0]);
							phase_d = PH_TWO;
						end else begin
							err_d   = 1'b1;
							phase_d = PH_DISCARD;
							part_d  = '0;
						end
					end
					PH_LAST: begin
						if (data_byte inside {[8'h80:8'hBF]}) begin
							push    = 1'b1;
							op.unit = {part_q, data_byte[5:0]};
							part_d  = '0;
							phase_d = PH_LEAD;
						end else begin
							err_d   = 1'b1;
							phase_d = PH_DISCARD;
							part_d  = '0;
						end
					end
					PH_TWO: begin
						if (data_byte inside {[8'h80:8'hBF]}) begin
							part_d  = {part_q[3:0], data_byte[5:0]};
							phase_d = PH_LAST;
						end else begin
							err_d   = 1'b1;
							phase_d = PH_DISCARD;
							part_d  = '0;
						end
					end
					PH_DISCARD: begin
					end
					default: begin
						err_d   = 1'b1;
						phase_d = PH_DISCARD;
						part_d  = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			part_q  <= '0;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			part_q  <= part_d;
			err_q   <= err_d;
		end
	end

`ifndef ASSERT_OFF
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && data_byte == '0 |=> phase_q == PH_LEAD && !err_q)
		else $error("terminator did not clear decode state");
	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_DISCARD && data_byte != '0 |-> !push)
		else $error("beat emitted while discarding");
`endif

endmodule

@@ rtl/core/u2u_queue.sv @@
module u2u_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2u_pkg::u2u_op_t push_op,
	input  logic             pop,
	output u2u_pkg::u2u_op_t pop_op,
	output logic             full,
	output logic             empty
);
	import u2u_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	u2u_op_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("queue written while full");
`endif

endmodule

@@ rtl/core/u2u_back.sv @@
module u2u_back #(
	parameter int COUNT_WIDTH = u2u_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  u2u_pkg::u2u_op_t            op,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [u2u_pkg::UNIT_W-1:0]  code_unit,
	output logic                        is_end,
	output logic                        status,
	output logic [u2u_pkg::UNIT_W-1:0]  unit_count
);
	import u2u_pkg::*;

	logic [COUNT_WIDTH-1:0] cnt_q, cnt_inc;
	logic                   valid_q;
	logic [UNIT_W-1:0]      unit_q, count_q;
	logic                   end_q, status_q;

	// counter holds at its maximum
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign pop     = !empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				cnt_q   <= op.is_end ? '0 : cnt_inc;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			end_q <= op.is_end;
			if (op.is_end) begin
				unit_q   <= '0;
				status_q <= op.bad;
				count_q  <= UNIT_W'(cnt_q);
			end else begin
				unit_q   <= op.unit;
				status_q <= 1'b0;
				count_q  <= UNIT_W'(cnt_inc);
			end
		end
	end

	assign out_valid  = valid_q;
	assign code_unit  = unit_q;
	assign is_end     = end_q;
	assign status     = status_q;
	assign unit_count = count_q;

`ifndef ASSERT_OFF
	a_end_resets_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && op.is_end |=> cnt_q == '0)
		else $error("unit count not cleared after end beat");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |-> !pop)
		else $error("output register overwritten while stalled");
`endif

endmodule

@@ rtl/core/utf8_to_ucs2_decoder_top.sv @@
// utf8 to ucs-2 decoder
// input channel: in_valid / in_stall carry one utf-8 byte per beat on data_byte;
// a zero byte ends the string
// output channel: out_valid / out_stall carry one result per beat: a code unit
// (is_end low) or the end-of-string result (is_end high, code_unit zero,
// status high if malformed input was seen, unit_count the saturated total)
// bytes that start or continue a sequence give no result
// a result is presented from the output register, loaded from the queue entry
// written when the byte that completes it is taken; decode is combinational,
// and the queue entry and the output register are the two stages
// throughput: one byte per cycle while in_stall is low, set by the combinational
// decode step in the front part and one queue pop per cycle in the back part
// reset: arst_n clears the decoder to expect a lead byte, empties the queue
// and drops out_valid
// receiver stall: the output register holds its beat, the queue fills, and
// in_stall rises once both queue entries are taken
module utf8_to_ucs2_decoder_top #(
	parameter int COUNT_WIDTH = u2u_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [u2u_pkg::BYTE_W-1:0]  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [u2u_pkg::UNIT_W-1:0]  code_unit,
	output logic                        is_end,
	output logic                        status,
	output logic [u2u_pkg::UNIT_W-1:0]  unit_count
);
	import u2u_pkg::*;

	logic    accept, push, pop, full, empty;
	u2u_op_t push_op, pop_op;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	u2u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.op        (push_op)
	);

	u2u_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.full    (full),
		.empty   (empty)
	);

	u2u_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.op         (pop_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_unit  (code_unit),
		.is_end     (is_end),
		.status     (status),
		.unit_count (unit_count)
	);

endmodule

@@ dv/testbench.sv @@
module testbench;
	import u2u_pkg::*;

	localparam int CNT_W       = COUNT_WIDTH_DEF;
	localparam int MAX_GAP     = 6;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCH_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 10;
	localparam int RAND_BYTES  = 700;

	typedef enum logic [1:0] {
		SEEK_LEAD,
		LAST_CONT,
		TWO_CONT,
		SKIP_REST
	} seq_phase_t;

	typedef struct {
		logic [UNIT_W-1:0] unit;
		logic              is_end;
		logic              status;
		logic [UNIT_W-1:0] count;
	} ucs2_beat_t;

	class utf8_scoreboard;
		seq_phase_t        phase;
		logic [PART_W-1:0] partial;
		logic              err_seen;
		logic [CNT_W-1:0]  units;
		ucs2_beat_t        expected_units[$];
		int                fail_count;

		function new();
			phase = SEEK_LEAD;
			partial = '0;
			err_seen = 1'b0;
			units = '0;
			fail_count = 0;
		endfunction

		function void restart_string();
			phase = SEEK_LEAD;
			partial = '0;
			err_seen = 1'b0;
			units = '0;
		endfunction

		function void flag_malformed();
			err_seen = 1'b1;
			phase = SKIP_REST;
			partial = '0;
		endfunction

		// work out what one accepted input byte produces
		function void note_byte(logic [BYTE_W-1:0] b);
			ucs2_beat_t        r;
			logic [UNIT_W-1:0] u;
			logic              emit;
			emit = 1'b0;
			u = '0;
			if (b == 8'h00) begin
				r.unit = '0;
				r.is_end = 1'b1;
				r.status = err_seen | (phase != SEEK_LEAD);
				r.count = 16'(units);
				expected_units.push_back(r);
				restart_string();
				return;
			end
			case (phase)
				SEEK_LEAD: begin
					if (b <= 8'h7F) begin
						emit = 1'b1;
						u = {8'h00, b};
					end else if (b[7:5] == 3'b110) begin
						partial = {5'b0, b[4:0]};
						phase = LAST_CONT;
					end else if (b[7:4] == 4'b1110) begin
						partial = {6'b0, b[3:0]};
						phase = TWO_CONT;
					end else begin
						flag_malformed();
					end
				end
				LAST_CONT: begin
					if (b[7:6] == 2'b10) begin
						emit = 1'b1;
						u = {partial, b[5:0]};
						partial = '0;
						phase = SEEK_LEAD;
					end else begin
						flag_malformed();
					end
				end
				TWO_CONT: begin
					if (b[7:6] == 2'b10) begin
						partial = {partial[3:0], b[5:0]};
						phase = LAST_CONT;
					end else begin
						flag_malformed();
					end
				end
				default: ;
			endcase
			if (emit) begin
				// counter holds at its top value, units still come out
				if (units != '1)
					units = units + 1'b1;
				r.unit = u;
				r.is_end = 1'b0;
				r.status = 1'b0;
				r.count = 16'(units);
				expected_units.push_back(r);
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			fail_count++;
		endtask

		task check_result(ucs2_beat_t got);
			ucs2_beat_t want;
			if (expected_units.size() == 0) begin
				report($sformatf("unexpected beat unit=%h end=%b", got.unit, got.is_end));
			end else begin
				want = expected_units.pop_front();
				if (got.unit !== want.unit)
					report($sformatf("code_unit %h, want %h", got.unit, want.unit));
				if (got.is_end !== want.is_end)
					report($sformatf("is_end %b, want %b", got.is_end, want.is_end));
				if (got.status !== want.status)
					report($sformatf("status %b, want %b", got.status, want.status));
				if (got.count !== want.count)
					report($sformatf("unit_count %h, want %h", got.count, want.count));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [UNIT_W-1:0] code_unit;
	logic              is_end;
	logic              status;
	logic [UNIT_W-1:0] unit_count;

	utf8_scoreboard sb = new();
	bit no_idle = 1'b0;
	bit hold_off_req = 1'b0;
	int bytes_sent = 0;

	utf8_to_ucs2_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_unit  (code_unit),
		.is_end     (is_end),
		.status     (status),
		.unit_count (unit_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task send_byte(logic [BYTE_W-1:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task send_code(logic [UNIT_W-1:0] cp);
		if (cp < 16'h0080) begin
			send_byte(cp[7:0]);
		end else if (cp < 16'h0800) begin
			send_byte({3'b110, cp[10:6]});
			send_byte({2'b10, cp[5:0]});
		end else begin
			send_byte({4'b1110, cp[15:12]});
			send_byte({2'b10, cp[11:6]});
			send_byte({2'b10, cp[5:0]});
		end
	endtask

	function automatic logic [UNIT_W-1:0] rand_code();
		case ($urandom_range(0, 2))
			0:       return 16'($urandom_range(1, 16'h007F));
			1:       return 16'($urandom_range(16'h0080, 16'h07FF));
			default: return 16'($urandom_range(16'h0800, 16'hFFFF));
		endcase
	endfunction

	// one string: mostly well-formed characters, some noise, maybe cut short
	task send_random_string();
		int n_chars;
		n_chars = $urandom_range(0, 12);
		for (int i = 0; i < n_chars; i++) begin
			if ($urandom_range(0, 9) < 8)
				send_code(rand_code());
			else
				send_byte(8'($urandom_range(1, 255)));
		end
		if ($urandom_range(0, 9) == 0)
			send_byte({4'b1110, 4'($urandom)});
		send_byte(8'h00);
	endtask

	// receiver: draws a stall per beat, one long hold-off on request
	initial begin
		int gap;
		ucs2_beat_t got;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.unit = code_unit;
			got.is_end = is_end;
			got.status = status;
			got.count = unit_count;
			sb.check_result(got);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCH_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-, two- and three-byte forms at their extremes, overlong and surrogate
		send_byte(8'h41);
		send_byte(8'h7F);
		send_byte(8'hC2); send_byte(8'h80);
		send_byte(8'hDF); send_byte(8'hBF);
		send_byte(8'hC0); send_byte(8'h80);
		send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
		send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
		send_byte(8'h00);
		// empty string
		send_byte(8'h00);
		// bad leads, then discarding
		send_byte(8'h80); send_byte(8'h41); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'h00);
		send_byte(8'hF0); send_byte(8'h00);
		// bad continuations
		send_byte(8'hC3); send_byte(8'h41); send_byte(8'h00);
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'hC0); send_byte(8'h00);
		// terminator inside a sequence
		send_byte(8'hE2); send_byte(8'h00);
		send_byte(8'hC3); send_byte(8'h00);

		// long receiver hold-off while the sender keeps offering beats
		hold_off_req = 1'b1;
		bytes_sent = 0;
		while (bytes_sent < RAND_BYTES) begin
			no_idle = ($urandom_range(0, 5) == 0);
			send_random_string();
		end
		no_idle = 1'b0;
		hold_off_req = 1'b1;
		send_random_string();

		in_valid <= 1'b0;
		while (sb.expected_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.expected_units.size() != 0)
			sb.report("results still expected at end of run");
		if (sb.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ utf8_to_ucs2_decoder_top.f @@
rtl/core/u2u_pkg.sv
rtl/core/u2u_front.sv
rtl/core/u2u_queue.sv
rtl/core/u2u_back.sv
rtl/core/utf8_to_ucs2_decoder_top.sv
dv/testbench.sv
